@@ sv/mandelbrot_escape_time_assert.svh @@
// ----------------------------------------------------------------------------
// mandelbrot escape-time assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

`ifndef ASSERT_OFF

// implication check, sampled on the rising clock, off during reset
`define MBE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never hold outside reset
`define MBE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define MBE_ASSERT(lbl, clk, rstn, prop, msg)
`define MBE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ sv/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// shared constants and types of the mandelbrot escape-time block
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  localparam int unsigned FracBitsDef   = 28;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned CountWidth    = 12;

  localparam logic [CountWidth-1:0] LimitReset = CountWidth'(511);

  // apb register file
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam logic [ApbAddrWidth-3:0] RegMaxIter = '0;

  // core status seen by the top level
  typedef struct packed {
    logic busy;       // a point is being iterated
    logic res_pend;   // result waits in the output register
  } mbe_stat_t;

endpackage

`default_nettype wire

@@ sv/mbe_if.sv @@
// ----------------------------------------------------------------------------
// mbe_if
// valid/ready channels for points and iteration counts
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_in_if
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] c_real;
  logic signed [COORD_WIDTH-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_out_if
  import mbe_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

@@ sv/mandelbrot_escape_time.sv @@
// each iteration steps through S_XX, S_YY, S_XY and S_UPD: x*x, y*y and x*y share one
// multiplier, then z is updated; the last escape test runs in S_XY, and S_DONE loads the
// count once the output register is free; one point at a time, taken only in S_IDLE
// reset: asynchronous active-low, clears the sequencer and sets the limit to 511
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time iteration of one complex point per transaction, apb limit reg
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // apb configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready,
  // point in, count out
  mbe_in_if.sink                       in_i,
  mbe_out_if.source                    out_o
);

  logic [CountWidth-1:0] limit_q;
  logic                  reg_sel;
  logic                  reg_wr;
  mbe_stat_t             core_stat;

  // register index is the word address; byte offset bits are ignored
  assign reg_sel = (paddr[ApbAddrWidth-1:2] == RegMaxIter);
  assign reg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (reg_wr) begin
      limit_q <= pwdata[CountWidth-1:0];
    end
  end

  // read back the limit; other addresses read zero
  assign prdata = reg_sel ? {{(ApbDataWidth - CountWidth){1'b0}}, limit_q} : '0;

  // iteration engine: sequencer around one shared multiplier
  mbe_core #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .c_real_i   (in_i.c_real),
    .c_imag_i   (in_i.c_imag),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .count_o    (out_o.iteration_count),
    .stat_o     (core_stat)
  );

  // a count never exceeds the limit in force
  `MBE_ASSERT(a_count_le_limit, clk_i, rst_ni, out_o.valid |-> (out_o.iteration_count <= limit_q), "iteration count above limit")

  // an accepted transaction makes the core busy on the next cycle
  `MBE_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> (core_stat.busy && !in_i.ready), "core not busy after accept")

  // no new point is taken while one is being iterated
  `MBE_ASSERT_NEVER(a_ready_while_busy, clk_i, rst_ni, core_stat.busy && in_i.ready, "input ready while busy")

  // a fresh result appears only when the core finishes a point
  `MBE_ASSERT(a_result_from_core, clk_i, rst_ni, $rose(core_stat.res_pend) |-> $past(core_stat.busy), "result without a point")

endmodule

`default_nettype wire

@@ sv/mbe_mul.sv @@
// ----------------------------------------------------------------------------
// mbe_mul
// shared signed multiplier with a registered full-width product
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [COORD_WIDTH-1:0]   a_i,
  input  wire logic signed [COORD_WIDTH-1:0]   b_i,
  output logic signed      [2*COORD_WIDTH-1:0] p_o
);

  logic signed [2*COORD_WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ sv/mbe_core.sv @@
// ----------------------------------------------------------------------------
// mbe_core
// sequencer that runs z = z*z + c through one shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_core
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [CountWidth-1:0]         limit_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] c_real_i,
  input  wire logic signed [COORD_WIDTH-1:0] c_imag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [CountWidth-1:0]              count_o,
  output mbe_stat_t                          stat_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned PW = 2 * COORD_WIDTH;
  localparam logic [PW:0] FourVal = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_DONE
  } state_e;

  state_e                state_q;
  logic                  out_valid_q;
  logic [CountWidth-1:0] count_q;
  logic [CountWidth-1:0] it_q;

  logic signed [W-1:0]  cx_q, cy_q, x_q, y_q;
  logic signed [PW-1:0] x2_q, y2_q;

  logic signed [W-1:0]  mul_a, mul_b;
  logic                 mul_en;
  logic signed [PW-1:0] prod;

  logic [PW:0]          mag_sum;
  logic                 stop;
  logic signed [PW:0]   diff, diff_sh;
  logic [PW+1:0]        nx_full;
  logic signed [PW-1:0] xy_sh;
  logic [PW:0]          ny_full;
  logic [W-1:0]         nx, ny;
  logic                 nx_ovf, ny_ovf;

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = x_q;
    mul_b  = x_q;
    mul_en = 1'b0;
    case (state_q)
      S_XX: begin
        mul_en = 1'b1;
      end
      S_YY: begin
        mul_a  = y_q;
        mul_b  = y_q;
        mul_en = 1'b1;
      end
      S_XY: begin
        mul_b  = y_q;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mbe_mul #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // escape test in S_XY: x2_q holds x*x, the product register holds y*y
  assign mag_sum = {1'b0, x2_q} + {1'b0, prod};
  assign stop    = (it_q >= limit_i) || (mag_sum >= FourVal);

  // update in S_UPD: the product register holds x*y
  assign diff    = $signed({x2_q[PW-1], x2_q}) - $signed({y2_q[PW-1], y2_q});
  assign diff_sh = diff >>> FRAC_BITS;
  assign nx_full = {diff_sh[PW], diff_sh} + {{(PW + 2 - W){cx_q[W-1]}}, cx_q};
  assign xy_sh   = prod >>> (FRAC_BITS - 1);
  assign ny_full = {xy_sh[PW-1], xy_sh} + {{(PW + 1 - W){cy_q[W-1]}}, cy_q};

  // saturate when the bits above the coordinate range disagree
  assign nx_ovf = !((&nx_full[PW+1:W-1]) || !(|nx_full[PW+1:W-1]));
  assign ny_ovf = !((&ny_full[PW:W-1]) || !(|ny_full[PW:W-1]));

  always_comb begin
    nx = nx_full[W-1:0];
    if (nx_ovf) begin
      nx = nx_full[PW+1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end
    ny = ny_full[W-1:0];
    if (ny_ovf) begin
      ny = ny_full[PW] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end
  end

  // point and iterate registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cx_q <= c_real_i;
          cy_q <= c_imag_i;
          x_q  <= c_real_i;
          y_q  <= c_imag_i;
        end
      end
      S_YY: begin
        x2_q <= prod;
      end
      S_XY: begin
        y2_q <= prod;
      end
      S_UPD: begin
        x_q <= nx;
        y_q <= ny;
      end
      default: begin
      end
    endcase
  end

  // sequencer with the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      it_q        <= '0;
    end else begin
      // load a finished count, or drop the one just taken
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            it_q    <= '0;
            state_q <= S_XX;
          end
        end
        S_XX: begin
          state_q <= S_YY;
        end
        S_YY: begin
          state_q <= S_XY;
        end
        S_XY: begin
          state_q <= stop ? S_DONE : S_UPD;
        end
        S_UPD: begin
          it_q    <= it_q + CountWidth'(1);
          state_q <= S_XX;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            count_q     <= it_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign count_o         = count_q;
  assign stat_o.busy     = (state_q != S_IDLE);
  assign stat_o.res_pend = out_valid_q;

endmodule

`default_nettype wire

@@ dv/tb_mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// self-checking testbench: points go in over a valid/ready channel, every
// returned iteration count is compared with an in-bench escape-time predictor;
// the iteration limit is reprogrammed over apb between drained phases
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
  import mbe_pkg::*;

  // q4.28 coordinates, products kept at full width with headroom
  localparam int unsigned WideW      = 2 * CoordWidthDef + 2;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned IdlePct    = 24;

  localparam logic signed [WideW-1:0] EscapeBound = WideW'(1) << (2 * FracBitsDef + 2);
  localparam logic signed [WideW-1:0] CoordMax    = WideW'(2147483647);
  localparam logic signed [WideW-1:0] CoordMin    = -CoordMax - WideW'(1);

  // byte address of the limit register
  localparam logic [ApbAddrWidth-1:0] MaxIterAddr = {RegMaxIter, 2'b00};

  typedef struct {
    logic signed [CoordWidthDef-1:0] re;
    logic signed [CoordWidthDef-1:0] im;
  } point_t;

  typedef struct {
    point_t                c;
    logic [CountWidth-1:0] count;
  } count_exp_t;

  logic clk_i;
  logic rst_ni;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  mbe_in_if #(.COORD_WIDTH(CoordWidthDef)) pt_if ();
  mbe_out_if                               cnt_if ();

  mandelbrot_escape_time #(
    .COORD_WIDTH (CoordWidthDef),
    .FRAC_BITS   (FracBitsDef)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (pt_if),
    .out_o   (cnt_if)
  );

  // points waiting for the driver, and counts waiting for the block
  point_t     pending_points[$];
  count_exp_t exp_counts[$];

  logic [CountWidth-1:0] limit_now;   // limit the block currently holds
  logic                  idle_en;     // random gaps on both channels
  logic                  pt_taken;    // point accepted at the last rising edge
  int unsigned           err_cnt;
  int unsigned           n_checked;
  int unsigned           n_settings;
  int unsigned           cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // escape-time predictor
  // ---------------------------------------------------------------------------

  // clamp to the signed coordinate range
  function automatic logic signed [WideW-1:0] clamp_coord(input logic signed [WideW-1:0] v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  // z starts at c; count iterations while below the limit and |z|^2 < 4
  function automatic logic [CountWidth-1:0] predict_escape_count(
    input point_t                c,
    input logic [CountWidth-1:0] limit
  );
    logic signed [WideW-1:0] cx, cy, x, y, xsq, ysq, xy;
    int n;
    cx = c.re;
    cy = c.im;
    x  = cx;
    y  = cy;
    n  = 0;
    while (n < int'(limit)) begin
      xsq = x * x;
      ysq = y * y;
      // escape test on the exact squares, 2*frac fraction bits
      if (xsq + ysq >= EscapeBound) break;
      xy = x * y;
      // arithmetic shifts round toward minus infinity
      x = clamp_coord(((xsq - ysq) >>> FracBitsDef) + cx);
      y = clamp_coord((xy >>> (FracBitsDef - 1)) + cy);
      n++;
    end
    return CountWidth'(n);
  endfunction

  // ---------------------------------------------------------------------------
  // point driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_points
    point_t p;
    if (rst_ni) begin
      // a new point only once the current one is gone
      if (!pt_if.valid || pt_taken) begin
        pt_taken = 1'b0;
        if (pending_points.size() != 0 &&
            !(idle_en && $urandom_range(99) < IdlePct)) begin
          p = pending_points.pop_front();
          pt_if.valid  <= 1'b1;
          pt_if.c_real <= p.re;
          pt_if.c_imag <= p.im;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // count receiver: random back-pressure
  always @(negedge clk_i) begin
    cnt_if.ready <= !(idle_en && $urandom_range(99) < IdlePct);
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    count_exp_t e;
    point_t     c;
    // accepted point: predict its count with the limit in force now
    if (pt_if.valid && pt_if.ready) begin
      c.re    = pt_if.c_real;
      c.im    = pt_if.c_imag;
      e.c     = c;
      e.count = predict_escape_count(c, limit_now);
      exp_counts.push_back(e);
      pt_taken = 1'b1;
    end
    // returned count: compare with the oldest prediction
    if (cnt_if.valid && cnt_if.ready) begin
      if (exp_counts.size() == 0) begin
        $display("%0t: unexpected count transaction, got %0d", $time,
                 cnt_if.iteration_count);
        err_cnt++;
      end else begin
        e = exp_counts.pop_front();
        n_checked++;
        if (cnt_if.iteration_count !== e.count) begin
          $display("%0t: iteration_count mismatch for c=(%h,%h): expected %0d, got %0d",
                   $time, e.c.re, e.c.im, e.count, cnt_if.iteration_count);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d counts outstanding", $time, exp_counts.size());
      $display("mandelbrot_escape_time regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_point(input logic signed [31:0] re, input logic signed [31:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    pending_points.push_back(p);
  endtask

  // mostly points in the box around the set, where long orbits live;
  // the rest are full-range words so every input bit toggles
  task automatic add_random_points(input int unsigned n);
    int re, im;
    repeat (n) begin
      if ($urandom_range(99) < 20) begin
        re = $urandom;
        im = $urandom;
      end else begin
        // real in [-2.25, 0.75), imag in [-1.5, 1.5)
        re = int'($urandom_range(805306367)) - 603979776;
        im = int'($urandom_range(805306367)) - 402653184;
      end
      add_point(re, im);
    end
  endtask

  // sender holds off until every prediction has been matched
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_points.size() != 0 || pt_if.valid || exp_counts.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAddrWidth-1:0] addr,
                           input logic [ApbDataWidth-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // read back the limit register and compare with what it should hold
  task automatic check_limit_reg(input logic [CountWidth-1:0] want);
    logic [ApbDataWidth-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MaxIterAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got[CountWidth-1:0] !== want) begin
      $display("%0t: max_iterations readback mismatch: expected %0d, got %0d",
               $time, want, got[CountWidth-1:0]);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reprogram only with the block idle, once the pipeline has settled
  task automatic program_limit(input logic [CountWidth-1:0] lim);
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    apb_write(MaxIterAddr, ApbDataWidth'(lim));
    limit_now = lim;
    n_settings++;
    check_limit_reg(lim);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CountWidth-1:0] lim;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pt_if.valid  = 1'b0;
    pt_if.c_real = '0;
    pt_if.c_imag = '0;
    cnt_if.ready = 1'b0;
    limit_now    = LimitReset;
    idle_en      = 1'b1;
    pt_taken     = 1'b0;
    err_cnt      = 0;
    n_checked    = 0;
    n_settings   = 1;
    cycles       = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // limit out of reset
    check_limit_reg(LimitReset);

    // directed points at the reset limit
    add_point(32'sh0000_0000, 32'sh0000_0000);  // origin, never escapes
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);  // most positive corner
    add_point(32'sh8000_0000, 32'sh8000_0000);  // most negative corner
    add_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    add_point(32'sh2000_0000, 32'sh0000_0000);  // |c|^2 exactly 4, stops at once
    add_point(32'shE000_0000, 32'sh0000_0000);  // -2, also exactly on the bound
    add_point(32'shE000_0001, 32'sh0000_0000);  // one lsb inside -2
    add_point(32'sh0400_0000, 32'sh0000_0000);  // cusp at 0.25, slow convergence
    add_point(32'sh0400_0001, 32'sh0000_0000);  // just past the cusp
    add_point(32'shF000_0000, 32'sh0000_0000);  // -1, period two orbit
    add_point(32'sh0000_0000, 32'sh1000_0000);  // i, preperiodic
    add_point(32'sh0800_0000, 32'sh0800_0000);  // 0.5+0.5i, quick escape
    add_point(32'shF400_0000, 32'sh0199_9999);  // -0.75+0.1i, long escape
    add_point(32'sh16A0_9E66, 32'sh16A0_9E66);  // |c| just below 2 on the diagonal
    add_point(32'shFFFF_FFFF, 32'sh0000_0001);  // tiny c, negative real lsb

    // zero limit: count is 0 whatever the point
    program_limit('0);
    add_point(32'sh0000_0000, 32'sh0000_0000);
    add_point(32'sh7FFF_FFFF, 32'sh0000_0000);
    add_point(32'sh8000_0000, 32'sh8000_0000);
    add_point(32'shF000_0000, 32'sh0000_0000);

    // limit of one
    program_limit(CountWidth'(1));
    add_point(32'sh0000_0000, 32'sh0000_0000);
    add_point(32'sh2000_0000, 32'sh0000_0000);
    add_point(32'sh1FFF_FFFF, 32'sh0000_0000);
    add_point(32'sh8000_0000, 32'sh7FFF_FFFF);

    // largest limit, few points since inside ones take the full count
    program_limit('1);
    add_point(32'sh0000_0000, 32'sh0000_0000);
    add_point(32'shF000_0000, 32'sh0000_0000);
    add_random_points(6);

    // random phases, mostly small limits to keep the run short
    for (int ph = 0; ph < 8; ph++) begin
      lim = (ph == 3) ? CountWidth'(255) : CountWidth'($urandom_range(2, 100));
      program_limit(lim);
      // one phase runs both channels flat out
      idle_en = (ph != 5);
      if (ph == 2) begin
        // sender pauses mid-phase until all counts are back
        add_random_points(50);
        wait_drained();
        add_random_points(53);
      end else begin
        add_random_points(103);
      end
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);

    $display("checked %0d iteration counts across %0d limit settings (0, 1, 4095 among them)",
             n_checked, n_settings);
    if (err_cnt == 0) begin
      $display("mandelbrot_escape_time regression: pass");
    end else begin
      $display("mandelbrot_escape_time regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mbe_pkg.sv
sv/mbe_if.sv
sv/mbe_mul.sv
sv/mbe_core.sv
sv/mandelbrot_escape_time.sv
dv/tb_mandelbrot_escape_time.sv
